>>> hdl/kmru_pkg.sv
package kmru_pkg;

  localparam int KEY_W       = 32;
  localparam int HANDLE_W    = 4;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;
  localparam int KEEP_DEPTH  = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INVAL  = 1'b1
  } op_t;

  typedef struct packed {
    logic                mode;
    logic [KEY_W-1:0]    key;
    logic                create_ok;
    logic [HANDLE_W-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle;
    logic                created;
    logic                failed;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [KEY_W-1:0]    evicted_key;
    logic                dropped;
  } out_item_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic                create_ok;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_EVICT,
    ST_INSERT,
    ST_INVAL,
    ST_OUT
  } back_state_t;

endpackage

>>> hdl/kmru_front.sv
module kmru_front import kmru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      q_push,
  output cmd_t      q_data,
  input  q_status_t q_status
);

  logic fr_vld_r, fr_vld_nxt;
  cmd_t fr_cmd_r, fr_cmd_nxt;
  logic accept;

  always_comb begin
    q_push     = fr_vld_r && !q_status.full;
    in_stall   = fr_vld_r && q_status.full;
    accept     = in_valid && !in_stall;
    fr_vld_nxt = accept || (fr_vld_r && !q_push);
    fr_cmd_nxt = fr_cmd_r;
    if (accept) begin
      fr_cmd_nxt.op        = in_data.mode ? OP_INVAL : OP_LOOKUP;
      fr_cmd_nxt.key       = in_data.key;
      fr_cmd_nxt.create_ok = in_data.create_ok;
      fr_cmd_nxt.handle    = in_data.handle_in;
    end
  end

  assign q_data = fr_cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_cmd_r <= fr_cmd_nxt;
  end

endmodule

>>> hdl/kmru_queue.sv
module kmru_queue import kmru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_data,
  input  logic      pop,
  output cmd_t      pop_data,
  output q_status_t status
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  always_comb begin
    status.full  = (fill_r == FULL_FILL);
    status.empty = (fill_r == '0);
    pop_data     = entry_r[rd_ptr_r];
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    fill_nxt     = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/kmru_back.sv
module kmru_back import kmru_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  q_status_t        q_status,
  input  cmd_t             q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TAG_W  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CMP_W  = (SLOT_W > HANDLE_W) ? SLOT_W : HANDLE_W;
  localparam int EC_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_ENTRIES);
  localparam logic [EC_W-1:0]   MAX_EC    = EC_W'(MAX_ENTRIES);

  back_state_t           state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [MAX_ENTRIES-1:0] used_r, used_nxt;
  logic [SLOT_W-1:0]     order_r [MAX_ENTRIES];
  logic [SLOT_W-1:0]     order_nxt [MAX_ENTRIES];
  cmd_t                  cmd_r, cmd_nxt;
  out_item_t             res_r, res_nxt;
  logic [SLOT_W-1:0]     scan_r, scan_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]     cmp_slot_r, cmp_slot_nxt;
  logic                  cmp_used_r, cmp_used_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [TAG_W-1:0]      tag_mem [MAX_ENTRIES];
  logic [TAG_W-1:0]      tag_q_r;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  tag_we;

  logic [TAG_W-1:0]      key_tag;
  logic [SLOT_W-1:0]     tail_idx;
  logic [SLOT_W-1:0]     tail_slot;
  logic [CMP_W-1:0]      srch;
  logic [MAX_ENTRIES-1:0] pos_hit;
  logic                  pos_any;
  logic [SLOT_W-1:0]     pos_idx;
  logic [SLOT_W-1:0]     free_slot;
  logic                  free_any;
  logic [EC_W-1:0]       eff_cap;
  logic                  need_evict;
  logic                  tag_match;
  logic                  out_free;

  // list position of a slot, lowest free slot, effective capacity
  always_comb begin
    key_tag   = TAG_W'(cmd_r.key);
    tail_idx  = (count_r == '0) ? '0 : SLOT_W'(count_r - 1'b1);
    tail_slot = order_r[tail_idx];
    srch      = (state_r == ST_INVAL) ? CMP_W'(cmd_r.handle) : CMP_W'(slot_r);
    pos_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      pos_hit[i] = (CNT_W'(i) < count_r) && (CMP_W'(order_r[i]) == srch);
      if (pos_hit[i]) begin
        pos_idx = pos_idx | SLOT_W'(i);
      end
    end
    pos_any   = |pos_hit;
    free_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
    free_any = ~&used_r;
    if (cap_r == '0) begin
      eff_cap = EC_W'(1);
    end else if (EC_W'(cap_r) > MAX_EC) begin
      eff_cap = MAX_EC;
    end else begin
      eff_cap = EC_W'(cap_r);
    end
    need_evict = (EC_W'(count_r) >= eff_cap) && (count_r != '0);
    tag_match  = cmp_vld_r && cmp_used_r && (tag_q_r == key_tag);
    out_free   = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    count_nxt     = count_r;
    used_nxt      = used_r;
    order_nxt     = order_r;
    cmd_nxt       = cmd_r;
    res_nxt       = res_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_slot_nxt  = scan_r;
    cmp_used_nxt  = used_r[scan_r];
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    tag_we        = 1'b0;
    rd_addr       = scan_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          res_nxt   = '0;
          scan_nxt  = '0;
          state_nxt = (q_data.op == OP_INVAL) ? ST_INVAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tag_match) begin
          slot_nxt  = cmp_slot_r;
          state_nxt = ST_HIT;
        end else if (cmp_vld_r && (cmp_slot_r == LAST_SLOT)) begin
          state_nxt = ST_MISS;
        end else begin
          cmp_vld_nxt = 1'b1;
          if (scan_r != LAST_SLOT) begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      ST_HIT: begin
        res_nxt.hit    = 1'b1;
        res_nxt.handle = HANDLE_W'(slot_r);
        // the two most recent entries keep their place
        if (pos_any && (32'(pos_idx) >= KEEP_DEPTH)) begin
          order_nxt[0] = slot_r;
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (SLOT_W'(i) <= pos_idx) begin
              order_nxt[i] = order_r[i-1];
            end
          end
        end
        state_nxt = ST_OUT;
      end
      ST_MISS: begin
        if (!cmd_r.create_ok) begin
          res_nxt.failed = 1'b1;
          state_nxt      = ST_OUT;
        end else if (need_evict) begin
          rd_addr   = tail_slot;
          slot_nxt  = tail_slot;
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_INSERT;
        end
      end
      ST_EVICT: begin
        res_nxt.evicted        = 1'b1;
        res_nxt.evicted_handle = HANDLE_W'(slot_r);
        res_nxt.evicted_key    = KEY_W'(tag_q_r);
        used_nxt[slot_r]       = 1'b0;
        count_nxt              = count_r - 1'b1;
        state_nxt              = ST_INSERT;
      end
      ST_INSERT: begin
        if (free_any && (count_r < FULL_CNT)) begin
          tag_we              = 1'b1;
          used_nxt[free_slot] = 1'b1;
          order_nxt[0]        = free_slot;
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            order_nxt[i] = order_r[i-1];
          end
          count_nxt       = count_r + 1'b1;
          res_nxt.created = 1'b1;
          res_nxt.handle  = HANDLE_W'(free_slot);
        end else begin
          res_nxt.failed = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_INVAL: begin
        if (pos_any) begin
          for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            if (SLOT_W'(i) >= pos_idx) begin
              order_nxt[i] = order_r[i+1];
            end
          end
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (CMP_W'(j) == CMP_W'(cmd_r.handle)) begin
              used_nxt[j] = 1'b0;
            end
          end
          count_nxt       = count_r - 1'b1;
          res_nxt.dropped = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    order_r    <= order_nxt;
    cmd_r      <= cmd_nxt;
    res_r      <= res_nxt;
    scan_r     <= scan_nxt;
    cmp_slot_r <= cmp_slot_nxt;
    cmp_used_r <= cmp_used_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  // tag store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[free_slot] <= key_tag;
    end
    tag_q_r <= tag_mem[rd_addr];
  end

endmodule

>>> hdl/keyed_mru_pool_replacement.sv
// Keyed pool of up to MAX_ENTRIES entries held in recency order.
// Input channel (in_valid/in_stall/in_data): lookup-or-create by key, or
// invalidate by handle. Result channel (out_valid/out_stall/out_data):
// exactly one result item per input item, in input order.
// cfg_we/cfg_wdata write the capacity register; write only while idle.
// An input item passes a front register and a two-deep command queue, so
// up to three items are taken while the engine is busy or a result waits.
// The engine takes one item at a time from the queue and finishes it before
// popping the next. The tag store is scanned one slot per cycle through its
// single read port, which sets the engine's rate.
// Reset (synchronous, active low) empties the list, marks every slot free
// and sets capacity to 10; tags need no clearing, so no sweep follows.
// A stalled result is held in the output register; the engine then waits
// with its next result, and the queue and front fill before in_stall rises.
module keyed_mru_pool_replacement import kmru_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  logic      q_push;
  cmd_t      q_push_data;
  logic      q_pop;
  cmd_t      q_pop_data;
  q_status_t q_status;

  kmru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_push_data),
    .q_status (q_status)
  );

  kmru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  kmru_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hdl/kmru_checker.sv
module kmru_checker import kmru_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.hit, out_data.created, out_data.failed,
                            out_data.dropped}))
    else $error("result item carries more than one outcome");

  a_evict_creates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.created && !out_data.hit)
    else $error("eviction without a new entry");

  a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |->
      (out_data.evicted_handle == '0) && (out_data.evicted_key == '0))
    else $error("eviction fields set without an eviction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

endmodule

bind keyed_mru_pool_replacement kmru_checker u_kmru_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
